/* sv/soc_pkg.sv */
// ----------------------------------------------------------------------------
// soc_pkg
// shared types and constants for the substring occurrence counter
// ----------------------------------------------------------------------------
package soc_pkg;

   localparam int LETTER_W = 5;
   localparam int REQ_W = 2;
   localparam int COUNT_OUT_W = 17;

   localparam int SOC_PAT_MAX = 64;
   localparam longint unsigned SOC_COUNT_MAX = 64'd65536;

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_TEXT   = 2'd2,
      REQ_REPORT = 2'd3
   } soc_req_code_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic [LETTER_W-1:0] pat_letter;
      logic                pat_valid;
      logic [LETTER_W-1:0] txt_letter;
      logic                txt_valid;
   } soc_link_type;

   // control broadcast to every cell
   typedef struct packed {
      logic clear;
      logic shift_pat;
      logic shift_txt;
   } soc_cell_ctrl_type;

endpackage

/* sv/soc_req_if.sv */
// ----------------------------------------------------------------------------
// soc_req_if
// request channel: valid/ready handshake with request code and letter
// ----------------------------------------------------------------------------
interface soc_req_if
   import soc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [LETTER_W-1:0] letter_code;

   modport source (output valid, output req_type, output letter_code, input ready);
   modport sink (input valid, input req_type, input letter_code, output ready);
endinterface

/* sv/soc_rsp_if.sv */
// ----------------------------------------------------------------------------
// soc_rsp_if
// response channel: valid/ready handshake with count and truncation flag
// ----------------------------------------------------------------------------
interface soc_rsp_if
   import soc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [COUNT_OUT_W-1:0] match_count;
   logic                   pattern_truncated;

   modport source (output valid, output match_count, output pattern_truncated, input ready);
   modport sink (input valid, input match_count, input pattern_truncated, output ready);
endinterface

/* sv/soc_cell.sv */
// ----------------------------------------------------------------------------
// soc_cell
// one position of the matcher: a reversed pattern letter and a window letter,
// both shifted on from the neighbor, and a comparator between them
// ----------------------------------------------------------------------------
module soc_cell
   import soc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  soc_cell_ctrl_type ctrl,
   input  soc_link_type      link_prev,
   output soc_link_type      link_next,
   output logic              mismatch
);

   logic [LETTER_W-1:0] pat_ff, pat_in;
   logic [LETTER_W-1:0] txt_ff, txt_in;
   logic                pv_ff, pv_in;
   logic                tv_ff, tv_in;

   always_comb begin
      pat_in = ctrl.shift_pat ? link_prev.pat_letter : pat_ff;
      txt_in = ctrl.shift_txt ? link_prev.txt_letter : txt_ff;
      pv_in  = pv_ff;
      tv_in  = tv_ff;
      if (ctrl.clear) begin
         pv_in = 1'b0;
         tv_in = 1'b0;
      end else begin
         if (ctrl.shift_pat) begin
            pv_in = link_prev.pat_valid;
         end
         if (ctrl.shift_txt) begin
            tv_in = link_prev.txt_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      txt_ff <= txt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         tv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         tv_ff <= tv_in;
      end
   end

   // an active pattern position fails on an empty or differing window slot
   assign mismatch = pv_ff && (!tv_ff || (txt_ff != pat_ff));

   assign link_next.pat_letter = pat_ff;
   assign link_next.pat_valid  = pv_ff;
   assign link_next.txt_letter = txt_ff;
   assign link_next.txt_valid  = tv_ff;

endmodule

/* sv/substring_occurrence_counter.sv */
// ----------------------------------------------------------------------------
// substring_occurrence_counter
// counts overlapping occurrences of a loaded pattern in a letter stream
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  req      in   req.valid/req.ready  req_type, letter_code
//  rsp      out  rsp.valid/rsp.ready  match_count, pattern_truncated
//
//  one request word per cycle while req.ready is high; the cell row shifts on
//  accept and the match check and count update follow in the cycle after
//  a report answer is registered in s2_report, then in the response register
//  req.ready drops only while a second report waits behind an untaken answer
//  synchronous reset clears the valid bits of every cell, count and flag
// ----------------------------------------------------------------------------
module substring_occurrence_counter
   import soc_pkg::*;
#(
   parameter int              PAT_MAX   = SOC_PAT_MAX,
   parameter longint unsigned COUNT_MAX = SOC_COUNT_MAX
) (
   input  logic          clock,
   input  logic          reset,
   soc_req_if.sink       req,
   soc_rsp_if.source     rsp
);

   localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);

   soc_link_type      link [PAT_MAX+1];
   logic [PAT_MAX-1:0] mism;
   soc_cell_ctrl_type ctrl;

   logic accept;
   logic pat_full;
   logic s2_go;

   logic             s2_text_ff, s2_text_in;
   logic             s2_report_ff, s2_report_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             trunc_ff, trunc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_trunc_ff, rsp_trunc_in;

   assign s2_go    = !(s2_report_ff && rsp_valid_ff && !rsp.ready);
   assign req.ready = s2_go;
   assign accept   = req.valid && s2_go;
   assign pat_full = link[PAT_MAX].pat_valid;

   assign ctrl.clear     = accept && (req.req_type == REQ_CLEAR);
   assign ctrl.shift_pat = accept && (req.req_type == REQ_APPEND) && !pat_full;
   assign ctrl.shift_txt = accept && (req.req_type == REQ_TEXT);

   assign link[0].pat_letter = req.letter_code;
   assign link[0].pat_valid  = 1'b1;
   assign link[0].txt_letter = req.letter_code;
   assign link[0].txt_valid  = 1'b1;

   for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
      soc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .link_prev (link[k]),
         .link_next (link[k+1]),
         .mismatch  (mism[k])
      );
   end

   always_comb begin
      s2_text_in   = s2_text_ff;
      s2_report_in = s2_report_ff;
      if (s2_go) begin
         s2_text_in   = accept && (req.req_type == REQ_TEXT);
         s2_report_in = accept && (req.req_type == REQ_REPORT);
      end

      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (s2_text_ff && !(|mism) && (count_ff < CNT_W'(COUNT_MAX))) begin
         count_in = count_ff + CNT_W'(1);
      end

      trunc_in = trunc_ff;
      if (ctrl.clear) begin
         trunc_in = 1'b0;
      end else if (accept && (req.req_type == REQ_APPEND) && pat_full) begin
         trunc_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_count_in = rsp_count_ff;
      rsp_trunc_in = rsp_trunc_ff;
      if (s2_report_ff && s2_go) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
         rsp_trunc_in = trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_text_ff   <= 1'b0;
         s2_report_ff <= 1'b0;
         count_ff     <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_text_ff   <= s2_text_in;
         s2_report_ff <= s2_report_in;
         count_ff     <= count_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.match_count       = COUNT_OUT_W'(rsp_count_ff);
   assign rsp.pattern_truncated = rsp_trunc_ff;

endmodule

/* sv/soc_checker.sv */
// ----------------------------------------------------------------------------
// soc_checker
// port-level checks for the substring occurrence counter, bound to the top
// ----------------------------------------------------------------------------
module soc_checker
   import soc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [REQ_W-1:0]       req_type,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COUNT_OUT_W-1:0] match_count,
   input logic                   pattern_truncated
);

   logic acc_clear;
   logic acc_report;

   assign acc_clear  = req_valid && req_ready && (req_type == REQ_CLEAR);
   assign acc_report = req_valid && req_ready && (req_type == REQ_REPORT);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(match_count) && $stable(pattern_truncated))
      else $error("response word changed while stalled");

   a_rsp_after_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(acc_report, 2))
      else $error("response word without a report two cycles earlier");

   a_clear_report: assert property (@(posedge clock) disable iff (reset)
      acc_clear ##1 (acc_report && !rsp_valid)
      |=> ##1 (rsp_valid && (match_count == '0) && !pattern_truncated))
      else $error("report right after clear not empty");

endmodule

bind substring_occurrence_counter soc_checker u_soc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_type          (req.req_type),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .match_count       (rsp.match_count),
   .pattern_truncated (rsp.pattern_truncated)
);

/* sim/soc_count_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soc_count_checker
// Watches the request and report channels of the substring occurrence counter.
// It keeps its own pattern, text history, count and truncation flag, works out
// the answer due for every report word it sees accepted, and compares each
// accepted answer field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module soc_count_checker
   import soc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   soc_req_if   req_mon,
   soc_rsp_if   rsp_mon,
   output int   fail_count,
   output int   reports_waiting,
   output int   reports_checked
);

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] match_count;
      logic                   pattern_truncated;
   } count_report_type;

   logic [LETTER_W-1:0] pattern_letters [SOC_PAT_MAX];
   logic [LETTER_W-1:0] history [SOC_PAT_MAX];
   int unsigned         pattern_len;
   int unsigned         history_fill;
   longint unsigned     hits;
   logic                truncated;
   count_report_type    reports_due [$];
   int                  failures = 0;
   int                  checked = 0;
   int                  due_count = 0;

   assign fail_count = failures;
   assign reports_waiting = due_count;
   assign reports_checked = checked;

   task automatic forget_all();
      for (int k = 0; k < SOC_PAT_MAX; k++) begin
         pattern_letters[k] = '0;
         history[k] = '0;
      end
      pattern_len = 0;
      history_fill = 0;
      hits = 0;
      truncated = 1'b0;
   endtask

   task automatic take_word(input logic [REQ_W-1:0] kind, input logic [LETTER_W-1:0] letter);
      bit aligned;
      case (kind)
         REQ_CLEAR: begin
            forget_all();
         end
         REQ_APPEND: begin
            if (pattern_len < SOC_PAT_MAX) begin
               pattern_letters[pattern_len] = letter;
               pattern_len++;
            end else begin
               truncated = 1'b1;
            end
         end
         REQ_TEXT: begin
            for (int k = SOC_PAT_MAX - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = letter;
            if (history_fill < SOC_PAT_MAX) history_fill++;
            // newest letter lines up with the last pattern letter
            aligned = (history_fill >= pattern_len);
            for (int k = 0; k < pattern_len; k++) begin
               if (history[k] != pattern_letters[pattern_len - 1 - k]) aligned = 1'b0;
            end
            if (aligned && hits < SOC_COUNT_MAX) hits++;
         end
         default: begin
            reports_due.push_back({hits[COUNT_OUT_W-1:0], truncated});
         end
      endcase
   endtask

   initial forget_all();

   always @(posedge clock) begin
      count_report_type due;
      if (reset) begin
         forget_all();
         reports_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reports_due.size() == 0) begin
               failures++;
               $error("count report with none due: match_count %0d, pattern_truncated %0d",
                      rsp_mon.match_count, rsp_mon.pattern_truncated);
            end else begin
               due = reports_due.pop_front();
               checked++;
               if (rsp_mon.match_count !== due.match_count) begin
                  failures++;
                  $error("match_count: expected %0d, got %0d",
                         due.match_count, rsp_mon.match_count);
               end
               if (rsp_mon.pattern_truncated !== due.pattern_truncated) begin
                  failures++;
                  $error("pattern_truncated: expected %0d, got %0d",
                         due.pattern_truncated, rsp_mon.pattern_truncated);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) take_word(req_mon.req_type, req_mon.letter_code);
      end
      due_count = reports_due.size();
   end

endmodule

/* sim/substring_occurrence_counter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_occurrence_counter_tb
// Drives pattern, text, clear and report words into the substring occurrence
// counter: a directed opening, a full-pattern sweep, then random pattern/text
// sequences over phases of sender idling, receiver stalling and a long
// receiver hold-off. A checker beside the block predicts and compares every
// count report; this module gives the verdict.
// ----------------------------------------------------------------------------
module substring_occurrence_counter_tb;
   import soc_pkg::*;

   localparam int RANDOM_WORDS = 350;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic          clock;
   logic          reset;
   soc_req_if     req ();
   soc_rsp_if     rsp ();
   int            fail_count;
   int            reports_waiting;
   int            reports_checked;
   idle_mode_type idle_mode = IDLE_NONE;
   int            holds_asked = 0;
   int            holds_done = 0;
   int            words_sent = 0;

   substring_occurrence_counter dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   soc_count_checker count_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req),
      .rsp_mon         (rsp),
      .fail_count      (fail_count),
      .reports_waiting (reports_waiting),
      .reports_checked (reports_checked)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 71;
         IDLE_BOTH: return $urandom_range(99) < 13;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 71;
         IDLE_BOTH: return $urandom_range(99) < 13;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [LETTER_W-1:0] any_letter();
      return LETTER_W'($urandom_range(31));
   endfunction

   // letters from a narrow alphabet so that matches are frequent, or any letter for a span of 32 or more
   function automatic logic [LETTER_W-1:0] pick_letter(input int base, input int span);
      if (span >= 32) return any_letter();
      return LETTER_W'(base + $urandom_range(span - 1));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input soc_req_code_type kind, input logic [LETTER_W-1:0] letter);
      while (sender_idles()) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= kind;
      req.letter_code <= letter;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic run_sequence();
      int span;
      int base;
      int pat_len;
      int text_len;
      if ($urandom_range(9) < 8) send_word(REQ_CLEAR, any_letter());
      span = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 3);
      base = $urandom_range(31);
      pat_len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
      repeat (pat_len) send_word(REQ_APPEND, pick_letter(base, span));
      text_len = (pat_len > 5) ? pat_len + $urandom_range(4, 30) : $urandom_range(4, 30);
      repeat (text_len) begin
         case ($urandom_range(19))
            0, 1, 2: send_word(REQ_REPORT, any_letter());
            3: send_word(REQ_APPEND, pick_letter(base, span));
            4: send_word(REQ_CLEAR, any_letter());
            default: send_word(REQ_TEXT, pick_letter(base, span));
         endcase
      end
      send_word(REQ_REPORT, any_letter());
   endtask

   // receiver side, long hold-off counted here
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp.ready <= !receiver_stalls();
         end
      end
   end

   initial begin
      #2_000_000;
      $display("substring_occurrence_counter_tb NOT OK");
      $finish;
   end

   initial begin
      int phase_start;
      reset = 1'b1;
      req.valid = 1'b0;
      req.req_type = REQ_CLEAR;
      req.letter_code = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fresh block, empty pattern counts every letter
      send_word(REQ_REPORT, 5'd31);
      send_word(REQ_TEXT, 5'd0);
      send_word(REQ_TEXT, 5'd31);
      send_word(REQ_REPORT, 5'd0);
      // window too short, overlapping matches, pattern grown after text
      send_word(REQ_CLEAR, 5'd31);
      send_word(REQ_APPEND, 5'd0);
      send_word(REQ_APPEND, 5'd0);
      send_word(REQ_TEXT, 5'd0);
      send_word(REQ_REPORT, 5'd0);
      send_word(REQ_TEXT, 5'd0);
      send_word(REQ_TEXT, 5'd0);
      send_word(REQ_REPORT, 5'd31);
      send_word(REQ_APPEND, 5'd31);
      send_word(REQ_TEXT, 5'd31);
      send_word(REQ_TEXT, 5'd30);
      send_word(REQ_REPORT, 5'd0);

      // full pattern, one letter dropped, then a full-length match
      send_word(REQ_CLEAR, 5'd0);
      for (int k = 0; k < SOC_PAT_MAX; k++) send_word(REQ_APPEND, LETTER_W'(k));
      send_word(REQ_APPEND, 5'd31);
      for (int k = 0; k < SOC_PAT_MAX; k++) send_word(REQ_TEXT, LETTER_W'(k));
      send_word(REQ_REPORT, 5'd0);
      send_word(REQ_CLEAR, 5'd0);
      send_word(REQ_REPORT, 5'd0);

      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = idle_mode_type'(phase);
         phase_start = words_sent;
         if (phase == 0) begin
            // receiver holds off while reports keep coming
            holds_asked++;
            repeat (12) begin
               send_word(REQ_TEXT, any_letter());
               send_word(REQ_REPORT, any_letter());
            end
         end
         while (words_sent - phase_start < RANDOM_WORDS / 4) run_sequence();
      end

      req.valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (reports_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d request words and %0d checked count reports,", words_sent,
               reports_checked);
      $display("with truncation, idle phases and a long hold-off");
      if (fail_count == 0) begin
         $display("substring_occurrence_counter_tb OK");
      end else begin
         $display("substring_occurrence_counter_tb NOT OK");
      end
      $finish;
   end

endmodule
